>>> design/convex_hull_monotone_chain_unit_assert.svh
// assertion macros for the convex hull unit checker
// no dependencies
`ifndef CONVEX_HULL_MONOTONE_CHAIN_UNIT_ASSERT_SVH
`define CONVEX_HULL_MONOTONE_CHAIN_UNIT_ASSERT_SVH
`define CHK_IMPL(lbl, cond, conseq, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);
`define CHK_NEXT(lbl, cond, conseq, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);
`endif

>>> design/chmc_pkg.sv
// package for the convex hull unit: point type, sizes, helpers
// no dependencies
`default_nettype none
package chmc_pkg;
    localparam int MAX_POINTS_DEF = 32;
    localparam int COORD_W = 16;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } point_t;

    // lexicographic: a strictly before b
    function automatic logic pt_before(point_t a, point_t b);
        if (a.x != b.x)
            return a.x < b.x;
        return a.y < b.y;
    endfunction
endpackage
`default_nettype wire

>>> design/chmc_cross.sv
// shared cross product unit: two products registered, then subtract and sign
// depends on chmc_pkg
`default_nettype none
module chmc_cross (
    input  wire logic          clk,
    input  wire chmc_pkg::point_t o,
    input  wire chmc_pkg::point_t a,
    input  wire chmc_pkg::point_t b,
    output logic               left
);
    import chmc_pkg::*;
    logic signed [16:0] ax, ay, bx, by;
    logic signed [33:0] p1_reg, p2_reg;
    logic signed [34:0] diff;

    always_comb
    begin
        ax = 17'(a.x) - 17'(o.x);
        ay = 17'(a.y) - 17'(o.y);
        bx = 17'(b.x) - 17'(o.x);
        by = 17'(b.y) - 17'(o.y);
        diff = 35'(p1_reg) - 35'(p2_reg);
        left = diff > 0;
    end

    always_ff @(posedge clk)
    begin
        p1_reg <= ax * by;
        p2_reg <= ay * bx;
    end
endmodule
`default_nettype wire

>>> design/convex_hull_monotone_chain_unit.sv
// Collects points one per request until set_end. The set is then sorted by insertion
// sort, one compare/move per cycle, and the lower and upper hulls are built with one
// shared cross product unit, each test passing through S_TST0, S_TST1 and S_TST2.
// Vertices then stream out one per cycle on hull_valid; the receiver cannot stall.
// busy stays high from the closing request to the last vertex. Depends on chmc_pkg
// and chmc_cross.
`default_nettype none
module convex_hull_monotone_chain_unit #(
    parameter int MAX_POINTS = chmc_pkg::MAX_POINTS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic signed [15:0] px,
    input  wire logic signed [15:0] py,
    input  wire logic        set_end,
    output logic             hull_valid,
    output logic signed [15:0] hull_x,
    output logic signed [15:0] hull_y,
    output logic             hull_last,
    output logic             overflowed
);
    import chmc_pkg::*;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int SD = 2 * MAX_POINTS;
    localparam int TW = $clog2(SD + 1);
    localparam int SW = $clog2(SD);

    localparam logic [2:0] S_LOAD = 3'd0, S_SORT = 3'd1, S_HULL = 3'd2,
                           S_TST0 = 3'd3, S_TST1 = 3'd4, S_TST2 = 3'd5,
                           S_EMIT = 3'd6;

    point_t store [MAX_POINTS];
    point_t stk [SD];

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] count_reg;
    logic          drop_reg;
    logic [CW-1:0] i_reg, j_reg;   // sort outer/inner; hull scan index
    point_t        key_reg;
    logic [TW-1:0] top_reg, floor_reg, k_reg;
    logic          upper_reg;
    point_t        cur_reg, s2_reg, s1_reg;
    logic          left;
    logic          lim_reg;

    chmc_cross u_cross (.clk(clk), .o(s2_reg), .a(s1_reg), .b(cur_reg), .left(left));

    point_t sj1;
    always_comb
        sj1 = (j_reg != 0) ? store[IW'(j_reg - 1'b1)] : store[0];

    assign busy = state_reg != S_LOAD;

    logic [TW-1:0] n_pts;
    assign n_pts = TW'(count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            count_reg <= '0;
            drop_reg  <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
            key_reg   <= '0;
            top_reg   <= '0;
            floor_reg <= '0;
            k_reg     <= '0;
            upper_reg <= 1'b0;
            cur_reg   <= '0;
            s2_reg    <= '0;
            s1_reg    <= '0;
            lim_reg   <= 1'b0;
            hull_valid <= 1'b0;
            hull_x    <= '0;
            hull_y    <= '0;
            hull_last <= 1'b0;
            overflowed <= 1'b0;
        end
        else
        begin
            hull_valid <= 1'b0;
            unique case (state_reg)
                S_LOAD:
                begin
                    if (start)
                    begin
                        logic [CW-1:0] c;
                        c = count_reg;
                        if (count_reg < CW'(MAX_POINTS))
                        begin
                            store[IW'(count_reg)] <= '{x: px, y: py};
                            c = count_reg + 1'b1;
                            count_reg <= c;
                        end
                        else
                            drop_reg <= 1'b1;
                        if (set_end)
                        begin
                            state_reg <= S_SORT;
                            i_reg <= CW'(1);
                            j_reg <= CW'(1);
                            top_reg <= '0;
                        end
                    end
                end
                S_SORT:
                begin
                    if (i_reg >= count_reg)
                    begin
                        state_reg <= S_HULL;
                        i_reg <= '0;
                        upper_reg <= 1'b0;
                        floor_reg <= TW'(2);
                    end
                    else
                    begin
                        // j_reg == i_reg at first visit: capture key
                        if (j_reg == i_reg && !lim_reg)
                        begin
                            key_reg <= store[IW'(i_reg)];
                            lim_reg <= 1'b1;
                        end
                        else if (j_reg != 0 && pt_before(key_reg, sj1))
                        begin
                            store[IW'(j_reg)] <= sj1;
                            j_reg <= j_reg - 1'b1;
                        end
                        else
                        begin
                            store[IW'(j_reg)] <= key_reg;
                            i_reg <= i_reg + 1'b1;
                            j_reg <= i_reg + 1'b1;
                            lim_reg <= 1'b0;
                        end
                    end
                end
                S_HULL:
                begin
                    // pick next point to push, or switch to the upper hull, or go on to emit
                    if (!upper_reg && TW'(i_reg) >= n_pts)
                    begin
                        upper_reg <= 1'b1;
                        floor_reg <= top_reg + 1'b1;
                        i_reg <= count_reg - 1'b1;
                    end
                    else if (upper_reg && (i_reg == 0 || count_reg < CW'(2)))
                    begin
                        state_reg <= S_EMIT;
                        k_reg <= '0;
                    end
                    else
                    begin
                        cur_reg <= upper_reg ? store[IW'(i_reg - 1'b1)]
                                             : store[IW'(i_reg)];
                        state_reg <= S_TST0;
                    end
                end
                S_TST0:
                begin
                    if (top_reg >= floor_reg && top_reg >= TW'(2))
                    begin
                        s2_reg <= stk[SW'(top_reg - TW'(2))];
                        s1_reg <= stk[SW'(top_reg - TW'(1))];
                        state_reg <= S_TST1;
                    end
                    else
                    begin
                        if (top_reg < TW'(SD))
                        begin
                            stk[SW'(top_reg)] <= cur_reg;
                            top_reg <= top_reg + 1'b1;
                        end
                        i_reg <= upper_reg ? i_reg - 1'b1 : i_reg + 1'b1;
                        state_reg <= S_HULL;
                    end
                end
                S_TST1: state_reg <= S_TST2;
                S_TST2:
                begin
                    if (!left)
                        top_reg <= top_reg - 1'b1;
                    else
                    begin
                        if (top_reg < TW'(SD))
                        begin
                            stk[SW'(top_reg)] <= cur_reg;
                            top_reg <= top_reg + 1'b1;
                        end
                        i_reg <= upper_reg ? i_reg - 1'b1 : i_reg + 1'b1;
                        state_reg <= S_HULL;
                        s2_reg <= s2_reg;
                    end
                    if (!left)
                        state_reg <= S_TST0;
                end
                S_EMIT:
                begin
                    if (k_reg < top_reg && k_reg < TW'(MAX_POINTS + 1))
                    begin
                        hull_valid <= 1'b1;
                        hull_x <= stk[SW'(k_reg)].x;
                        hull_y <= stk[SW'(k_reg)].y;
                        hull_last <= (k_reg + 1'b1 == top_reg) ||
                                     (k_reg == TW'(MAX_POINTS));
                        overflowed <= drop_reg;
                        k_reg <= k_reg + 1'b1;
                    end
                    else
                    begin
                        state_reg <= S_LOAD;
                        count_reg <= '0;
                        drop_reg <= 1'b0;
                        top_reg <= '0;
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> design/chmc_checker.sv
// port-level checker for the convex hull unit, bound to the top level
// depends on convex_hull_monotone_chain_unit_assert.svh
`default_nettype none
`include "convex_hull_monotone_chain_unit_assert.svh"
module chmc_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic set_end,
    input wire logic hull_valid,
    input wire logic hull_last
);
    `CHK_NEXT(a_end_busy, start && !busy && set_end, busy, "closing request must raise busy")
    `CHK_IMPL(a_out_busy, hull_valid, busy, "vertex shown while idle")
    `CHK_NEXT(a_nofill, start && !busy && !set_end, !busy, "plain point must not start work")
    `CHK_NEXT(a_last_done, hull_valid && hull_last, !hull_valid, "vertex after closing vertex")
endmodule
bind convex_hull_monotone_chain_unit chmc_checker u_chk (.clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy), .set_end(set_end), .hull_valid(hull_valid),
    .hull_last(hull_last));
`default_nettype wire
